FILE: hdl/bnnd_pkg.sv
// Shared types, constants and the color source table of the Bayer demosaic unit.
`default_nettype none
package bnnd_pkg;

  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SAMPLE_W       = 16;
  localparam int COLOR_W        = 16;
  localparam int PATTERN_W      = 3;
  localparam int FRAME_WIDTH_W  = 13;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 16;

  localparam int FRAME_WIDTH_RESET  = 4096;
  localparam int FRAME_HEIGHT_RESET = 2048;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN      = 3'd0,
    REG_COLUMN_PHASE = 3'd1,
    REG_ROW_PHASE    = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } reg_index_t;

  typedef enum logic [PATTERN_W-1:0] {
    PAT_RGGB = 3'd0,
    PAT_BGGR = 3'd1,
    PAT_GBRG = 3'd2,
    PAT_GRBG = 3'd3,
    PAT_GBGR = 3'd4,
    PAT_RGBG = 3'd5,
    PAT_BGRG = 3'd6
  } pattern_t;

  typedef enum logic [2:0] {
    SRC_C    = 3'd0,
    SRC_L    = 3'd1,
    SRC_R    = 3'd2,
    SRC_U    = 3'd3,
    SRC_D    = 3'd4,
    SRC_ZERO = 3'd5
  } src_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   frame_end;
    logic   run_last;
  } result_t;

  // ph = {row parity, column parity}, ch = 0 red, 1 green, 2 blue
  function automatic src_t src_pick(input logic [PATTERN_W-1:0] pat, input logic [1:0] ph,
                                    input logic [1:0] ch);
    src_t       tbl [12];
    logic [3:0] idx;
    idx = 4'({2'b00, ph} * 4'd3) + {2'b00, ch};
    unique case (pattern_t'(pat))
      PAT_RGGB: tbl = '{SRC_C, SRC_R, SRC_D, SRC_L, SRC_C, SRC_D,
                        SRC_U, SRC_C, SRC_R, SRC_U, SRC_C, SRC_L};
      PAT_BGGR: tbl = '{SRC_D, SRC_R, SRC_C, SRC_D, SRC_C, SRC_L,
                        SRC_R, SRC_C, SRC_U, SRC_L, SRC_C, SRC_U};
      PAT_GBRG: tbl = '{SRC_R, SRC_C, SRC_D, SRC_L, SRC_C, SRC_U,
                        SRC_U, SRC_C, SRC_R, SRC_L, SRC_C, SRC_D};
      PAT_GRBG: tbl = '{SRC_D, SRC_C, SRC_R, SRC_U, SRC_C, SRC_L,
                        SRC_R, SRC_C, SRC_U, SRC_D, SRC_C, SRC_L};
      PAT_GBGR: tbl = '{SRC_D, SRC_C, SRC_R, SRC_L, SRC_U, SRC_C,
                        SRC_U, SRC_C, SRC_R, SRC_C, SRC_D, SRC_L};
      PAT_RGBG: tbl = '{SRC_C, SRC_R, SRC_D, SRC_L, SRC_C, SRC_U,
                        SRC_U, SRC_R, SRC_C, SRC_D, SRC_C, SRC_L};
      PAT_BGRG: tbl = '{SRC_D, SRC_R, SRC_C, SRC_U, SRC_C, SRC_L,
                        SRC_C, SRC_R, SRC_U, SRC_L, SRC_C, SRC_D};
      default:  tbl = '{default: SRC_ZERO};
    endcase
    return tbl[idx];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bnnd_ram.sv
// Generic simple RAM: one write port, two registered read ports with a shared enable.
`default_nettype none
module bnnd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bnnd_pick.sv
// Color source selection from the center sample and its four neighbors.
`default_nettype none
module bnnd_pick #(
  parameter int SAMPLE_BITS = bnnd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic [bnnd_pkg::PATTERN_W-1:0] pattern,
  input  wire logic                           x_par,
  input  wire logic                           y_par,
  input  wire logic                           black,
  input  wire logic [SAMPLE_BITS-1:0]         nb_c,
  input  wire logic [SAMPLE_BITS-1:0]         nb_l,
  input  wire logic [SAMPLE_BITS-1:0]         nb_r,
  input  wire logic [SAMPLE_BITS-1:0]         nb_u,
  input  wire logic [SAMPLE_BITS-1:0]         nb_d,
  output bnnd_pkg::pixel_t                    pix
);
  import bnnd_pkg::*;

  function automatic logic [COLOR_W-1:0] take(input src_t src, input logic [SAMPLE_BITS-1:0] c,
                                               input logic [SAMPLE_BITS-1:0] l,
                                               input logic [SAMPLE_BITS-1:0] r,
                                               input logic [SAMPLE_BITS-1:0] u,
                                               input logic [SAMPLE_BITS-1:0] d);
    logic [SAMPLE_BITS-1:0] v;
    unique case (src)
      SRC_C:   v = c;
      SRC_L:   v = l;
      SRC_R:   v = r;
      SRC_U:   v = u;
      SRC_D:   v = d;
      default: v = '0;
    endcase
    return COLOR_W'(v);
  endfunction

  src_t src_red;
  src_t src_green;
  src_t src_blue;

  always_comb begin
    if (black) begin
      src_red   = SRC_ZERO;
      src_green = SRC_ZERO;
      src_blue  = SRC_ZERO;
    end else begin
      src_red   = src_pick(pattern, {y_par, x_par}, 2'd0);
      src_green = src_pick(pattern, {y_par, x_par}, 2'd1);
      src_blue  = src_pick(pattern, {y_par, x_par}, 2'd2);
    end
  end

  assign pix.red   = take(src_red,   nb_c, nb_l, nb_r, nb_u, nb_d);
  assign pix.green = take(src_green, nb_c, nb_l, nb_r, nb_u, nb_d);
  assign pix.blue  = take(src_blue,  nb_c, nb_l, nb_r, nb_u, nb_d);

endmodule
`default_nettype wire

FILE: hdl/bnnd_out.sv
// Output register with a pending slot for the black bottom-row pixel.
`default_nettype none
module bnnd_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire bnnd_pkg::result_t first_res,
  input  wire logic              has_second,
  input  wire logic              second_frame_end,
  output logic                   free,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [47:0]            m_tdata,   // red, green, blue
  output logic                   m_tlast,   // frame_end
  output logic                   m_tuser    // run_last
);
  import bnnd_pkg::*;

  logic    o_valid;
  logic    o_second;
  logic    o_fe2;
  result_t o_res;

  assign free = !o_valid || (m_tready && !o_second);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      o_second <= 1'b0;
    end else if (load) begin
      o_valid  <= 1'b1;
      o_second <= has_second;
      o_fe2    <= second_frame_end;
      o_res    <= first_res;
    end else if (o_valid && m_tready) begin
      if (o_second) begin
        o_second        <= 1'b0;
        o_res.pix       <= '0;
        o_res.frame_end <= o_fe2;
        o_res.run_last  <= 1'b1;
      end else begin
        o_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_res.pix.blue, o_res.pix.green, o_res.pix.red};
  assign m_tlast  = o_res.frame_end;
  assign m_tuser  = o_res.run_last;

endmodule
`default_nettype wire

FILE: hdl/bayer_nearest_neighbor_demosaic_unit.sv
// Top level of the nearest-neighbor Bayer demosaic unit.
//
// Raw samples enter on the s_ stream in raster order, one per transaction:
// s_tdata carries the sample, s_tuser marks the first sample of a frame.
// Each position of row y gives one RGB pixel on the m_ stream while row y+1
// arrives; samples of row 0 give no pixel. In the last row each sample gives
// two pixels: the pixel above it, then its own black bottom-row pixel.
// m_tlast flags the last pixel of the frame, m_tuser the last pixel caused by
// one input sample. The right column and the bottom row are black.
// Samples pass the stage-1 register; pixels then load the output register.
// Throughput: one sample per cycle while m_tready is high; in the last row the
// single output register emits one pixel per cycle and s_tready drops while
// it holds a sample's second pixel.
// Two line buffers of MAX_WIDTH entries hold the previous rows; each has one
// write port and two read ports, with forwarding of the write in flight.
// Reset clears position and configuration (pattern RGGB, phases 0, width
// 4096 or MAX_WIDTH if less, height 2048); line contents stay undefined
// until written. When m_tready is low the output register holds and s_tready
// drops once the internal stage is full; no transaction is lost.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data.
`default_nettype none
module bayer_nearest_neighbor_demosaic_unit #(
  parameter int MAX_WIDTH   = bnnd_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = bnnd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [bnnd_pkg::SAMPLE_W-1:0]    s_tdata,   // sample
  input  wire logic                             s_tuser,   // frame_start
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [3*bnnd_pkg::COLOR_W-1:0]        m_tdata,   // red, green, blue
  output logic                                  m_tlast,   // frame_end
  output logic                                  m_tuser,   // run_last
  input  wire logic                             cfg_wr_en,
  input  wire logic [bnnd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bnnd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bnnd_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = FRAME_HEIGHT_W;
  localparam int RESET_W = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;

  // configuration
  logic [PATTERN_W-1:0] pattern;
  logic                 column_phase;
  logic                 row_phase;
  logic [COL_W-1:0]     w_last;
  logic [ROW_W-1:0]     h_last;
  logic [COL_W-1:0]     w_last_next;
  logic [ROW_W-1:0]     h_last_next;

  always_comb begin
    int unsigned fw;
    int unsigned fh;
    fw = 32'(cfg_data[FRAME_WIDTH_W-1:0]);
    fh = 32'(cfg_data[FRAME_HEIGHT_W-1:0]);
    if (fw < 2) begin
      fw = 2;
    end else if (fw > MAX_WIDTH) begin
      fw = MAX_WIDTH;
    end
    if (fh < 2) begin
      fh = 2;
    end
    w_last_next = COL_W'(fw - 1);
    h_last_next = ROW_W'(fh - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern      <= PAT_RGGB;
      column_phase <= 1'b0;
      row_phase    <= 1'b0;
      w_last       <= COL_W'(RESET_W - 1);
      h_last       <= ROW_W'(FRAME_HEIGHT_RESET - 1);
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_PATTERN:      pattern      <= cfg_data[PATTERN_W-1:0];
        REG_COLUMN_PHASE: column_phase <= cfg_data[0];
        REG_ROW_PHASE:    row_phase    <= cfg_data[0];
        REG_FRAME_WIDTH:  w_last       <= w_last_next;
        REG_FRAME_HEIGHT: h_last       <= h_last_next;
        default: ;
      endcase
    end
  end

  // input side: position and line buffer reads
  logic                   accept;
  logic                   s1_go;
  logic                   out_free;
  logic [COL_W-1:0]       column_count;
  logic [ROW_W-1:0]       row_count;
  logic [COL_W-1:0]       x;
  logic [COL_W-1:0]       xp1;
  logic [COL_W-1:0]       xm1;
  logic [ROW_W-1:0]       r;
  logic                   x_last;
  logic                   r_last;

  always_comb begin
    x = s_tuser ? '0 : column_count;
    r = s_tuser ? '0 : row_count;
    if (x > w_last) begin
      x = w_last;
    end
    if (r > h_last) begin
      r = h_last;
    end
    xp1    = x + 1'b1;
    xm1    = x - 1'b1;
    x_last = (x == w_last);
    r_last = (r == h_last);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (x_last) begin
        column_count <= '0;
        row_count    <= r_last ? '0 : r + 1'b1;
      end else begin
        column_count <= xp1;
        row_count    <= r;
      end
    end
  end

  // stage 1: line buffer data arrives
  logic                   s1_valid;
  logic [COL_W-1:0]       s1_x;
  logic [SAMPLE_BITS-1:0] s1_s;
  logic                   s1_x_last;
  logic                   s1_x_zero;
  logic                   s1_r_ge1;
  logic                   s1_r_ge2;
  logic                   s1_r_last;
  logic                   s1_x_par;
  logic                   s1_y_par;
  logic                   hit_c;
  logic                   hit_r;
  logic                   hit_l;
  logic [SAMPLE_BITS-1:0] fwd_upper;
  logic [SAMPLE_BITS-1:0] fwd_middle;
  logic [SAMPLE_BITS-1:0] mid_rd_c;
  logic [SAMPLE_BITS-1:0] mid_rd_r;
  logic [SAMPLE_BITS-1:0] up_rd_l;
  logic [SAMPLE_BITS-1:0] up_rd_c;
  logic [SAMPLE_BITS-1:0] m_c;
  logic [SAMPLE_BITS-1:0] m_r;
  logic [SAMPLE_BITS-1:0] u_l;
  logic [SAMPLE_BITS-1:0] u_c;
  logic [SAMPLE_BITS-1:0] nb_l;
  logic [SAMPLE_BITS-1:0] nb_r;
  logic [SAMPLE_BITS-1:0] nb_u;

  assign s1_go    = s1_valid && (!s1_r_ge1 || out_free);
  assign s_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x       <= x;
      s1_s       <= s_tdata[SAMPLE_BITS-1:0];
      s1_x_last  <= x_last;
      s1_x_zero  <= (x == '0);
      s1_r_ge1   <= (r >= ROW_W'(1));
      s1_r_ge2   <= (r >= ROW_W'(2));
      s1_r_last  <= r_last;
      s1_x_par   <= x[0] ^ column_phase;
      s1_y_par   <= ~r[0] ^ row_phase;
      hit_c      <= s1_go && (x == s1_x);
      hit_r      <= s1_go && (xp1 == s1_x);
      hit_l      <= s1_go && (xm1 == s1_x);
      fwd_upper  <= m_c;
      fwd_middle <= s1_s;
    end
  end

  bnnd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_middle (
    .clk    (clk),
    .we     (s1_go),
    .waddr  (s1_x),
    .wdata  (s1_s),
    .re     (accept),
    .raddr_a(x),
    .raddr_b(xp1),
    .rdata_a(mid_rd_c),
    .rdata_b(mid_rd_r)
  );

  bnnd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_upper (
    .clk    (clk),
    .we     (s1_go),
    .waddr  (s1_x),
    .wdata  (m_c),
    .re     (accept),
    .raddr_a(xm1),
    .raddr_b(x),
    .rdata_a(up_rd_l),
    .rdata_b(up_rd_c)
  );

  assign m_c  = hit_c ? fwd_middle : mid_rd_c;
  assign m_r  = hit_r ? fwd_middle : mid_rd_r;
  assign u_l  = hit_l ? fwd_upper  : up_rd_l;
  assign u_c  = hit_c ? fwd_upper  : up_rd_c;
  assign nb_r = s1_x_last ? '0 : m_r;
  assign nb_l = s1_x_zero ? '0 : u_l;
  assign nb_u = s1_r_ge2  ? u_c : '0;

  // color selection and output
  pixel_t  pix;
  result_t first_res;

  bnnd_pick #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_pick (
    .pattern(pattern),
    .x_par  (s1_x_par),
    .y_par  (s1_y_par),
    .black  (s1_x_last),
    .nb_c   (m_c),
    .nb_l   (nb_l),
    .nb_r   (nb_r),
    .nb_u   (nb_u),
    .nb_d   (s1_s),
    .pix    (pix)
  );

  assign first_res.pix       = pix;
  assign first_res.frame_end = 1'b0;
  assign first_res.run_last  = !s1_r_last;

  bnnd_out u_out (
    .clk             (clk),
    .rst             (rst),
    .load            (s1_go && s1_r_ge1),
    .first_res       (first_res),
    .has_second      (s1_r_last),
    .second_frame_end(s1_x_last),
    .free            (out_free),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .m_tuser         (m_tuser)
  );

endmodule
`default_nettype wire
